>>> hdl/ecf_pkg.sv
// Shared types, sizes and the control program of the Euler circuit finder.
package ecf_pkg;

	localparam int MAX_VERTICES = 8;
	localparam int PATH_DEPTH   = 37;
	localparam int SP_W         = $clog2(PATH_DEPTH + 1);
	localparam int ADDR_W       = $clog2(PATH_DEPTH);
	localparam int PC_W         = 4;
	localparam int CNT_W        = 4;

	typedef logic [2:0] vertex_t;
	typedef logic [MAX_VERTICES-1:0] row_t;

	typedef struct packed {
		logic [2:0] row_index;
		logic [7:0] row_bits;
		logic       last_row;
	} in_t;

	typedef struct packed {
		logic [2:0] vertex;
		logic       status;
		logic       last;
	} out_t;

	localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
	localparam logic [1:0] REG_START_VERTEX = 2'd1;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_CHK_INIT,
		OP_CHK_STEP,
		OP_WALK_INIT,
		OP_WALK,
		OP_LOAD_TOP,
		OP_EMIT_RD,
		OP_EMIT_OUT,
		OP_FAIL
	} op_t;

	typedef enum logic [3:0] {
		C_NONE,
		C_ALWAYS,
		C_NO_START,
		C_ODD,
		C_I_LT_N,
		C_CAN_PUSH,
		C_SP_NZ,
		C_OUT_BUSY,
		C_K_LT_LEN
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctl_t;

	typedef struct packed {
		logic no_start;
		logic odd;
		logic i_lt_n;
		logic can_push;
		logic sp_nz;
		logic out_busy;
		logic k_lt_len;
	} stat_t;

	localparam logic [PC_W-1:0] S_IDLE      = PC_W'(0);
	localparam logic [PC_W-1:0] S_CHK_INIT  = PC_W'(1);
	localparam logic [PC_W-1:0] S_CHK_ROW   = PC_W'(2);
	localparam logic [PC_W-1:0] S_CHK_LOOP  = PC_W'(3);
	localparam logic [PC_W-1:0] S_WALK_INIT = PC_W'(4);
	localparam logic [PC_W-1:0] S_WALK      = PC_W'(5);
	localparam logic [PC_W-1:0] S_LOAD_TOP  = PC_W'(6);
	localparam logic [PC_W-1:0] S_EMIT_RD   = PC_W'(7);
	localparam logic [PC_W-1:0] S_EMIT_OUT  = PC_W'(8);
	localparam logic [PC_W-1:0] S_EMIT_LOOP = PC_W'(9);
	localparam logic [PC_W-1:0] S_DONE      = PC_W'(10);
	localparam logic [PC_W-1:0] S_FAIL      = PC_W'(11);
	localparam logic [PC_W-1:0] S_FAIL_DONE = PC_W'(12);

	function automatic ctl_t cw(input op_t o, input cond_t c, input logic [PC_W-1:0] t);
		ctl_t w;
		w.op     = o;
		w.cond   = c;
		w.target = t;
		return w;
	endfunction

	function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
		ctl_t w;
		case (pc)
			S_IDLE:      w = cw(OP_LOAD,      C_NO_START, S_IDLE);
			S_CHK_INIT:  w = cw(OP_CHK_INIT,  C_NONE,     S_IDLE);
			S_CHK_ROW:   w = cw(OP_CHK_STEP,  C_ODD,      S_FAIL);
			S_CHK_LOOP:  w = cw(OP_NOP,       C_I_LT_N,   S_CHK_ROW);
			S_WALK_INIT: w = cw(OP_WALK_INIT, C_NONE,     S_IDLE);
			S_WALK:      w = cw(OP_WALK,      C_CAN_PUSH, S_WALK);
			S_LOAD_TOP:  w = cw(OP_LOAD_TOP,  C_SP_NZ,    S_WALK);
			S_EMIT_RD:   w = cw(OP_EMIT_RD,   C_NONE,     S_IDLE);
			S_EMIT_OUT:  w = cw(OP_EMIT_OUT,  C_OUT_BUSY, S_EMIT_OUT);
			S_EMIT_LOOP: w = cw(OP_NOP,       C_K_LT_LEN, S_EMIT_RD);
			S_DONE:      w = cw(OP_NOP,       C_ALWAYS,   S_IDLE);
			S_FAIL:      w = cw(OP_FAIL,      C_OUT_BUSY, S_FAIL);
			S_FAIL_DONE: w = cw(OP_NOP,       C_ALWAYS,   S_IDLE);
			default:     w = cw(OP_NOP,       C_ALWAYS,   S_IDLE);
		endcase
		return w;
	endfunction

endpackage

>>> hdl/ecf_seq.sv
// Step counter and control store fetch with conditional jumps.
module ecf_seq import ecf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctl_t  ctl
);

	logic [PC_W-1:0] pc_q;
	logic            take;

	assign ctl = ucode(pc_q);

	always_comb begin
		case (ctl.cond)
			C_NONE:     take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_START: take = stat.no_start;
			C_ODD:      take = stat.odd;
			C_I_LT_N:   take = stat.i_lt_n;
			C_CAN_PUSH: take = stat.can_push;
			C_SP_NZ:    take = stat.sp_nz;
			C_OUT_BUSY: take = stat.out_busy;
			C_K_LT_LEN: take = stat.k_lt_len;
			default:    take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else if (take) begin
			pc_q <= ctl.target;
		end else begin
			pc_q <= pc_q + PC_W'(1);
		end
	end

endmodule

>>> hdl/ecf_dp.sv
// Datapath: adjacency rows, walk stack, circuit store, counters and result register.
module ecf_dp import ecf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_t        in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output out_t       out_item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data,
	input  ctl_t       ctl,
	output stat_t      stat
);

	logic [CNT_W-1:0] vcount_q;
	vertex_t          start_q;
	row_t             rows_q [MAX_VERTICES];
	logic [CNT_W-1:0] i_q;
	vertex_t          top_q;
	logic [SP_W-1:0]  sp_q;
	logic [SP_W-1:0]  push_q;
	logic [SP_W-1:0]  clen_q;
	logic [SP_W-1:0]  k_q;
	vertex_t          stk_mem [PATH_DEPTH];
	vertex_t          circ_mem [PATH_DEPTH];
	vertex_t          stk_rd_q;
	vertex_t          circ_rd_q;
	logic             out_valid_q;
	out_t             out_q;

	logic [CNT_W-1:0] n;
	row_t             mask;
	vertex_t          start_eff;
	row_t             rd_row;
	row_t             masked;
	vertex_t          x;
	logic             can_push;
	logic             in_fire;
	logic             out_busy;
	logic             out_load;
	logic [SP_W-1:0]  sp_m1;
	logic [SP_W-1:0]  sp_m2;
	logic [SP_W-1:0]  circ_ra;

	always_comb begin
		if (vcount_q == '0) begin
			n = CNT_W'(1);
		end else if (vcount_q > CNT_W'(MAX_VERTICES)) begin
			n = CNT_W'(MAX_VERTICES);
		end else begin
			n = vcount_q;
		end
		for (int j = 0; j < MAX_VERTICES; j++) begin
			mask[j] = (CNT_W'(j) < n);
		end
		start_eff = (CNT_W'(start_q) < n) ? start_q : '0;
	end

	always_comb begin
		rd_row = (ctl.op == OP_CHK_STEP) ? rows_q[i_q[2:0]] : rows_q[top_q];
		masked = (CNT_W'(top_q) < n || ctl.op == OP_CHK_STEP) ? (rd_row & mask) : '0;
		x = '0;
		for (int j = MAX_VERTICES - 1; j >= 0; j--) begin
			if (masked[j]) begin
				x = vertex_t'(j);
			end
		end
	end

	assign can_push = (masked != '0) && (push_q < SP_W'(PATH_DEPTH - 1));
	assign in_ready = (ctl.op == OP_LOAD);
	assign in_fire  = in_valid && in_ready;
	assign out_busy = out_valid_q && !out_ready;
	assign out_load = ((ctl.op == OP_EMIT_OUT) || (ctl.op == OP_FAIL)) && !out_busy;
	assign sp_m1    = sp_q - SP_W'(1);
	assign sp_m2    = sp_q - SP_W'(2);
	assign circ_ra  = clen_q - SP_W'(1) - k_q;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		stat.no_start = !(in_valid && in_item.last_row);
		stat.odd      = ^masked;
		stat.i_lt_n   = (i_q < n);
		stat.can_push = can_push;
		stat.sp_nz    = (sp_q != '0);
		stat.out_busy = out_busy;
		stat.k_lt_len = (k_q < clen_q);
	end

	always_ff @(posedge clk) begin
		if (in_fire && (int'(in_item.row_index) < MAX_VERTICES)) begin
			rows_q[in_item.row_index] <= in_item.row_bits[MAX_VERTICES-1:0];
		end
		if (ctl.op == OP_WALK && can_push) begin
			rows_q[top_q][x] <= 1'b0;
			rows_q[x][top_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_WALK && can_push) begin
			stk_mem[sp_m1[ADDR_W-1:0]] <= top_q;
		end
		stk_rd_q <= stk_mem[sp_m2[ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_WALK && !can_push) begin
			circ_mem[clen_q[ADDR_W-1:0]] <= top_q;
		end
		circ_rd_q <= circ_mem[circ_ra[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= CNT_W'(MAX_VERTICES);
			start_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_VERTEX_COUNT: vcount_q <= cfg_data;
				REG_START_VERTEX: start_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			top_q       <= '0;
			sp_q        <= '0;
			push_q      <= '0;
			clen_q      <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (ctl.op)
				OP_CHK_INIT: i_q <= '0;
				OP_CHK_STEP: i_q <= i_q + CNT_W'(1);
				OP_WALK_INIT: begin
					top_q  <= start_eff;
					sp_q   <= SP_W'(1);
					push_q <= '0;
					clen_q <= '0;
					k_q    <= '0;
				end
				OP_WALK: begin
					if (can_push) begin
						top_q  <= x;
						sp_q   <= sp_q + SP_W'(1);
						push_q <= push_q + SP_W'(1);
					end else begin
						sp_q   <= sp_m1;
						clen_q <= clen_q + SP_W'(1);
					end
				end
				OP_LOAD_TOP: top_q <= stk_rd_q;
				OP_EMIT_OUT: begin
					if (!out_busy) begin
						out_q.vertex <= circ_rd_q;
						out_q.status <= 1'b0;
						out_q.last   <= (k_q + SP_W'(1) == clen_q);
						k_q          <= k_q + SP_W'(1);
					end
				end
				OP_FAIL: begin
					if (!out_busy) begin
						out_q.vertex <= '0;
						out_q.status <= 1'b1;
						out_q.last   <= 1'b1;
						clen_q       <= '0;
						sp_q         <= '0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

>>> hdl/euler_circuit_finder.sv
// Top level of the Euler circuit finder: sequencer plus datapath.
//
// channel  direction  handshake             payload
// in       in         in_valid/in_ready     in_item   (row_index, row_bits, last_row)
// out      out        out_valid/out_ready   out_item  (vertex, status, last)
// cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A row without last_row is stored and the sequencer stays idle. A last row starts a run:
// the parity check over the vertices, the walk with its pushes and pops, then the
// emitting of the circuit vertex by vertex, all stepped by the control store.
// Reset clears the sequencer, counters and result register; rows start undefined.
// A stalled output holds the sequencer in its emit or fail step; no row is taken during a run.
module euler_circuit_finder import ecf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_t        in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output out_t       out_item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data
);

	ctl_t  ctl;
	stat_t stat;

	ecf_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	ecf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.stat      (stat)
	);

endmodule

>>> hdl/ecf_checker.sv
// Port-level assertions for the Euler circuit finder and their bind.
module ecf_checker import ecf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input in_t        in_item,
	input logic       out_valid,
	input logic       out_ready,
	input out_t       out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	a_fail_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status |-> out_item.last && out_item.vertex == 3'd0)
		else $error("no-circuit result malformed");

	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.last |-> !in_ready)
		else $error("row taken during a run");

	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.last_row |=> !in_ready)
		else $error("last row did not start a run");

endmodule

bind euler_circuit_finder ecf_checker u_chk (.*);

>>> bench/euler_circuit_finder_tb.sv
// Self-checking bench for the Euler circuit finder: directed graphs first, then random runs.
module euler_circuit_finder_tb;
	import ecf_pkg::*;

	localparam int           PLAN_LEN          = 26;
	localparam int           ITEM_GOAL         = 360;
	localparam int           SETTLE            = 16;
	localparam int           LONG_HOLD         = 400;
	localparam logic         STATUS_VERTEX     = 1'b0;
	localparam logic         STATUS_NO_CIRCUIT = 1'b1;
	localparam logic [1:0]   REG_SPARE2        = 2'd2;
	localparam logic [1:0]   REG_SPARE3        = 2'd3;
	localparam out_t         LONE_START        = '{vertex: 3'd0, status: STATUS_VERTEX, last: 1'b1};
	localparam out_t         NO_CIRCUIT        = '{vertex: 3'd0, status: STATUS_NO_CIRCUIT,
		last: 1'b1};

	typedef struct packed {
		logic       is_reg;
		logic [1:0] reg_sel;
		logic [3:0] reg_val;
		in_t        row;
		logic       fixed;
		out_t       answer;
	} step_t;

	typedef struct packed {
		logic fixed;
		out_t res;
	} hint_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	in_t        in_item   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_t       out_item;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [3:0] cfg_data  = '0;

	logic [7:0] adj_copy [MAX_VERTICES];
	logic [3:0] count_copy = 4'd8;
	logic [2:0] start_copy = 3'd0;
	out_t       walk_results[$];
	out_t       expected_circuit[$];
	hint_t      directed_answer_q[$];
	step_t      plan [PLAN_LEN];
	int         mismatches  = 0;
	int         checked     = 0;
	int         items_sent  = 0;
	int         burst_left  = 0;
	bit         valid_up    = 0;
	bit         hold_asked  = 0;

	euler_circuit_finder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

	task automatic report_mismatch(input string field, input logic [7:0] got,
			input logic [7:0] want);
		$display("result %0d: %s is %0d, expected %0d", checked, field, got, want);
		mismatches++;
	endtask

	// Store the row; a last row runs the parity check and the walk on the local copy.
	task automatic absorb_row(input in_t row);
		logic [7:0] mask;
		logic [7:0] r;
		logic [2:0] stk [PATH_DEPTH];
		logic [2:0] popped [PATH_DEPTH];
		logic [2:0] v;
		logic [2:0] x;
		logic [2:0] origin;
		out_t       res;
		int         n;
		int         sp;
		int         pushes;
		int         len;
		bit         odd;
		walk_results.delete();
		adj_copy[row.row_index] = row.row_bits;
		if (!row.last_row)
			return;
		n = (count_copy == 0) ? 1 : (count_copy > MAX_VERTICES) ? MAX_VERTICES : count_copy;
		mask = '0;
		for (int i = 0; i < n; i++)
			mask[i] = 1'b1;
		origin = (start_copy < n) ? start_copy : 3'd0;
		odd = 0;
		for (int i = 0; i < n; i++)
			if (^(adj_copy[i] & mask))
				odd = 1;
		if (odd) begin
			walk_results.push_back(NO_CIRCUIT);
			return;
		end
		stk[0] = origin;
		sp = 1;
		pushes = 0;
		len = 0;
		while (sp != 0) begin
			v = stk[sp-1];
			r = (v < n) ? (adj_copy[v] & mask) : 8'd0;
			if (r == 0 || pushes >= PATH_DEPTH - 1 || sp >= PATH_DEPTH) begin
				if (len < PATH_DEPTH) begin
					popped[len] = v;
					len++;
				end
				sp--;
			end else begin
				x = 3'd0;
				while (!r[x])
					x++;
				stk[sp] = x;
				sp++;
				pushes++;
				adj_copy[v][x] = 1'b0;
				adj_copy[x][v] = 1'b0;
			end
		end
		for (int k = 0; k < len; k++) begin
			res.vertex = popped[len-1-k];
			res.status = STATUS_VERTEX;
			res.last = (k == len - 1);
			walk_results.push_back(res);
		end
	endtask

	always @(posedge clk) begin : watch
		hint_t hint;
		out_t  want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_VERTEX_COUNT: count_copy = cfg_data;
					REG_START_VERTEX: start_copy = cfg_data[2:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				hint = directed_answer_q.pop_front();
				absorb_row(in_item);
				if (hint.fixed)
					expected_circuit.push_back(hint.res);
				else
					foreach (walk_results[k])
						expected_circuit.push_back(walk_results[k]);
			end
			if (out_valid && out_ready) begin
				checked++;
				if (expected_circuit.size() == 0) begin
					report_mismatch("unrequested result, vertex", 8'(out_item.vertex), 8'd0);
				end else begin
					want = expected_circuit.pop_front();
					if (out_item.vertex !== want.vertex)
						report_mismatch("vertex", 8'(out_item.vertex), 8'(want.vertex));
					if (out_item.status !== want.status)
						report_mismatch("status", 8'(out_item.status), 8'(want.status));
					if (out_item.last !== want.last)
						report_mismatch("last", 8'(out_item.last), 8'(want.last));
				end
			end
		end
	end

	initial begin : receiver
		int mode;
		int span;
		bit held;
		mode = 0;
		span = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (hold_asked && !held) begin
				held = 1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (span == 0) begin
				mode = $urandom_range(0, 2);
				span = $urandom_range(10, 80);
			end
			span--;
			case (mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= ($urandom_range(0, 1) == 1);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic pace();
		int gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				valid_up = 0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_row(input in_t row, input logic fixed, input out_t answer);
		directed_answer_q.push_back('{fixed: fixed, res: answer});
		in_item <= row;
		in_valid <= 1'b1;
		valid_up = 1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		pace();
	endtask

	task automatic drain();
		if (valid_up) begin
			in_valid <= 1'b0;
			valid_up = 0;
		end
		@(posedge clk);
		while (expected_circuit.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] sel, input logic [3:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Random symmetric graph with even degrees, sometimes with one bit flipped, rows sent in order or reversed.
	task automatic send_graph(input int n);
		logic [7:0] g [MAX_VERTICES];
		logic [7:0] mask;
		in_t        row;
		int         density;
		int         r;
		int         a;
		int         b;
		bit         rev;
		bit         e;
		density = $urandom_range(15, 85);
		mask = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			g[i] = 8'($urandom_range(0, 255));
			if (i < n)
				mask[i] = 1'b1;
		end
		for (int i = 0; i < n; i++)
			for (int j = 0; j <= i; j++) begin
				e = ($urandom_range(0, 99) < density);
				g[i][j] = e;
				g[j][i] = e;
			end
		for (int i = 0; i < n - 1; i++)
			if (^(g[i] & mask)) begin
				g[i][n-1] = ~g[i][n-1];
				g[n-1][i] = ~g[n-1][i];
			end
		if (^(g[n-1] & mask))
			g[n-1][n-1] = ~g[n-1][n-1];
		if ($urandom_range(0, 5) == 0) begin
			a = $urandom_range(0, n - 1);
			b = $urandom_range(0, 7);
			g[a][b] = ~g[a][b];
		end
		rev = ($urandom_range(0, 1) == 1);
		for (int k = 0; k < n; k++) begin
			r = rev ? n - 1 - k : k;
			row.row_index = 3'(r);
			row.row_bits = g[r];
			row.last_row = (k == n - 1);
			send_row(row, 1'b0, '0);
		end
	endtask

	function automatic step_t row_step(input int idx, input int bits, input int last);
		step_t s;
		s = '0;
		s.row.row_index = 3'(idx);
		s.row.row_bits = 8'(bits);
		s.row.last_row = (last != 0);
		return s;
	endfunction

	function automatic step_t fixed_row(input int idx, input int bits, input int last,
			input out_t ans);
		step_t s;
		s = row_step(idx, bits, last);
		s.fixed = 1'b1;
		s.answer = ans;
		return s;
	endfunction

	function automatic step_t reg_step(input logic [1:0] sel, input int val);
		step_t s;
		s = '0;
		s.is_reg = 1'b1;
		s.reg_sel = sel;
		s.reg_val = 4'(val);
		return s;
	endfunction

	initial begin : stimulus
		in_t row;
		int  phase;
		int  vc;
		int  st;
		int  n;
		int  runs;
		int  count_corner [4];
		int  start_corner [4];
		count_corner = '{8, 1, 0, 15};
		start_corner = '{0, 7, 15, 3};
		plan = '{
			row_step(0, 0, 0), row_step(1, 0, 0), row_step(2, 0, 0), row_step(3, 0, 0),
			row_step(4, 0, 0), row_step(5, 0, 0), row_step(6, 0, 0),
			fixed_row(7, 0, 1, LONE_START),
			fixed_row(3, 8'h02, 1, NO_CIRCUIT),
			row_step(0, 255, 0), row_step(1, 255, 0), row_step(2, 255, 0),
			row_step(3, 255, 0), row_step(4, 255, 0), row_step(5, 255, 0),
			row_step(6, 255, 0), row_step(7, 255, 1),
			reg_step(REG_VERTEX_COUNT, 0), reg_step(REG_START_VERTEX, 7),
			fixed_row(0, 255, 1, NO_CIRCUIT),
			reg_step(REG_VERTEX_COUNT, 15), reg_step(REG_START_VERTEX, 5),
			row_step(5, 8'h21, 1),
			row_step(6, 8'h00, 1),
			reg_step(REG_SPARE2, 10), reg_step(REG_SPARE3, 5)
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				drain();
				write_reg(plan[i].reg_sel, plan[i].reg_val);
				cfg_valid <= 1'b0;
			end else begin
				send_row(plan[i].row, plan[i].fixed, plan[i].answer);
			end
		end
		phase = 0;
		while (items_sent < ITEM_GOAL) begin
			drain();
			vc = (phase < 4) ? count_corner[phase] : $urandom_range(0, 15);
			st = (phase < 4) ? start_corner[phase] : $urandom_range(0, 15);
			write_reg(REG_VERTEX_COUNT, 4'(vc));
			write_reg(REG_START_VERTEX, 4'(st));
			if ($urandom_range(0, 4) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE2 : REG_SPARE3,
					4'($urandom_range(0, 15)));
			cfg_valid <= 1'b0;
			if (phase == 2)
				hold_asked = 1;
			n = (vc == 0) ? 1 : (vc > MAX_VERTICES) ? MAX_VERTICES : vc;
			runs = $urandom_range(3, 8);
			repeat (runs) begin
				if ($urandom_range(0, 3) == 0) begin
					row.row_index = 3'($urandom_range(0, 7));
					row.row_bits = 8'($urandom_range(0, 255));
					row.last_row = ($urandom_range(0, 3) == 0);
					send_row(row, 1'b0, '0);
				end else begin
					send_graph(n);
				end
			end
			phase++;
		end
		drain();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> euler_circuit_finder.f
hdl/ecf_pkg.sv
hdl/ecf_seq.sv
hdl/ecf_dp.sv
hdl/euler_circuit_finder.sv
hdl/ecf_checker.sv
bench/euler_circuit_finder_tb.sv
